>>> hw/rtl/rld_pkg.sv
package rld_pkg;

  localparam int FIELD_BYTES_MAX = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_EXTENT = 2'd0;
  localparam logic [1:0] ST_END    = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic [63:0] offset;
  } rld_entry_t;

  function automatic logic [63:0] low_bytes_mask(input logic [2:0] p);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (3'(i) < p) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/rld_if.sv
interface rld_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [63:0] start_vcn;
  logic [7:0]         data_byte;
  logic               byte_is_last;

  modport source (output valid, output action, output start_vcn, output data_byte,
                  output byte_is_last, input ready);
  modport sink (input valid, input action, input start_vcn, input data_byte,
                input byte_is_last, output ready);
endinterface

interface rld_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] first_lcn;
  logic signed [63:0] extent_next_vcn;
  logic signed [63:0] span_clusters;
  logic               is_virtual;
  logic signed [63:0] cluster_total;

  modport source (output valid, output status, output first_lcn, output extent_next_vcn,
                  output span_clusters, output is_virtual, output cluster_total,
                  input ready);
  modport sink (input valid, input status, input first_lcn, input extent_next_vcn,
                input span_clusters, input is_virtual, input cluster_total,
                output ready);
endinterface

>>> hw/rtl/rld_front.sv
module rld_front (
  input  logic               clk,
  input  logic               rst_n,
  rld_in_if.sink             in_chan,
  output logic               push_valid,
  output rld_pkg::rld_entry_t push_entry,
  input  logic               queue_full
);
  import rld_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_OFFSET = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  len_left_r, len_left_nxt;
  logic [3:0]  off_left_r, off_left_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [63:0] len_acc_r, len_acc_nxt;
  logic [63:0] off_acc_r, off_acc_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [63:0] b_shift;
  logic [63:0] sign_fill;

  assign in_chan.ready = !queue_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;
  assign last          = in_chan.byte_is_last;
  assign b_shift       = {56'd0, b} << {pos_r, 3'b000};
  assign sign_fill     = (b[7] && (pos_r != 3'd7)) ? ~low_bytes_mask(pos_r + 3'd1) : 64'd0;

  always_comb begin
    phase_nxt    = phase_r;
    len_left_nxt = len_left_r;
    off_left_nxt = off_left_r;
    pos_nxt      = pos_r;
    len_acc_nxt  = len_acc_r;
    off_acc_nxt  = off_acc_r;
    push_valid   = 1'b0;
    push_entry   = '{op: OP_RUN, value: len_acc_r, offset: off_acc_r};
    if (accept) begin
      if (!in_chan.action) begin
        phase_nxt    = PH_HEADER;
        len_left_nxt = '0;
        off_left_nxt = '0;
        pos_nxt      = '0;
        len_acc_nxt  = '0;
        off_acc_nxt  = '0;
        push_valid   = 1'b1;
        push_entry   = '{op: OP_START, value: in_chan.start_vcn, offset: 64'd0};
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (b == 8'd0) begin
              phase_nxt       = PH_IDLE;
              push_valid      = 1'b1;
              push_entry.op   = OP_END;
            end else begin
              len_left_nxt = b[3:0];
              off_left_nxt = b[7:4];
              if ((b[3:0] > 4'(FIELD_BYTES_MAX)) || (b[7:4] > 4'(FIELD_BYTES_MAX)) || last) begin
                phase_nxt     = PH_IDLE;
                push_valid    = 1'b1;
                push_entry.op = OP_BAD;
              end else begin
                len_acc_nxt = '0;
                off_acc_nxt = '0;
                pos_nxt     = '0;
                phase_nxt   = (b[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
              end
            end
          end
          PH_LENGTH: begin
            len_acc_nxt  = len_acc_r | b_shift;
            pos_nxt      = pos_r + 3'd1;
            len_left_nxt = len_left_r - 4'd1;
            if (last) begin
              phase_nxt     = PH_IDLE;
              push_valid    = 1'b1;
              push_entry.op = OP_BAD;
            end else if (len_left_nxt == 4'd0) begin
              pos_nxt = '0;
              if (off_left_r == 4'd0) begin
                phase_nxt  = PH_HEADER;
                push_valid = 1'b1;
                push_entry = '{op: OP_RUN, value: len_acc_nxt, offset: off_acc_r};
              end else begin
                phase_nxt = PH_OFFSET;
              end
            end
          end
          PH_OFFSET: begin
            off_acc_nxt  = (off_acc_r & low_bytes_mask(pos_r)) | b_shift | sign_fill;
            pos_nxt      = pos_r + 3'd1;
            off_left_nxt = off_left_r - 4'd1;
            if (last) begin
              phase_nxt     = PH_IDLE;
              push_valid    = 1'b1;
              push_entry.op = OP_BAD;
            end else if (off_left_nxt == 4'd0) begin
              pos_nxt    = '0;
              phase_nxt  = PH_HEADER;
              push_valid = 1'b1;
              push_entry = '{op: OP_RUN, value: len_acc_r, offset: off_acc_nxt};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      len_left_r <= '0;
      off_left_r <= '0;
      pos_r      <= '0;
      len_acc_r  <= '0;
      off_acc_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      len_left_r <= len_left_nxt;
      off_left_r <= off_left_nxt;
      pos_r      <= pos_nxt;
      len_acc_r  <= len_acc_nxt;
      off_acc_r  <= off_acc_nxt;
    end
  end

endmodule

>>> hw/rtl/rld_queue.sv
module rld_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  rld_pkg::rld_entry_t push_entry,
  output logic                full,
  output logic                pop_valid,
  output rld_pkg::rld_entry_t pop_entry,
  input  logic                pop_ready
);
  import rld_pkg::*;

  rld_entry_t          store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  logic                pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = store_r[rd_ptr_r];
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/rld_back.sv
module rld_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rld_pkg::rld_entry_t q_entry,
  output logic                q_ready,
  rld_out_if.source           out_chan
);
  import rld_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] cpos_r, cpos_nxt;
  logic [63:0] vpos_r, vpos_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [1:0]  status_r;
  logic [63:0] lcn_r, next_vcn_r, length_r, total_r;
  logic        virt_r;

  logic        pop;
  logic        virt;
  logic        emit;

  assign q_ready = !out_valid_r || out_chan.ready;
  assign pop     = q_valid && q_ready;
  assign virt    = (q_entry.offset == 64'd0);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    cpos_nxt      = cpos_r;
    vpos_nxt      = vpos_r;
    sum_nxt       = sum_r;
    emit          = 1'b0;
    if (pop) begin
      unique case (q_entry.op) inside
        OP_START: begin
          cpos_nxt = '0;
          vpos_nxt = q_entry.value;
          sum_nxt  = '0;
        end
        OP_RUN: begin
          cpos_nxt = cpos_r + q_entry.offset;
          vpos_nxt = vpos_r + q_entry.value;
          sum_nxt  = virt ? sum_r : sum_r + q_entry.value;
          emit     = 1'b1;
        end
        OP_END, OP_BAD: begin
          emit = 1'b1;
        end
        default: begin
        end
      endcase
      if (emit) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cpos_r      <= '0;
      vpos_r      <= '0;
      sum_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cpos_r      <= cpos_nxt;
      vpos_r      <= vpos_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (q_entry.op == OP_RUN) begin
        status_r   <= ST_EXTENT;
        lcn_r      <= cpos_nxt;
        next_vcn_r <= vpos_nxt;
        length_r   <= q_entry.value;
        virt_r     <= virt;
      end else begin
        status_r   <= (q_entry.op == OP_END) ? ST_END : ST_BAD;
        lcn_r      <= '0;
        next_vcn_r <= '0;
        length_r   <= '0;
        virt_r     <= 1'b0;
      end
      total_r <= sum_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = status_r;
  assign out_chan.first_lcn       = lcn_r;
  assign out_chan.extent_next_vcn = next_vcn_r;
  assign out_chan.span_clusters   = length_r;
  assign out_chan.is_virtual      = virt_r;
  assign out_chan.cluster_total   = total_r;

endmodule

>>> hw/rtl/run_list_to_extent_decoder.sv
// Accepts one start or run list byte per cycle while the two-entry queue has room.
// A byte that completes a run, ends the list or makes it malformed puts a result in
// the queue, which moves it to the output register when free; other bytes give none.
// Throughput is one item per cycle while output is ready; the queue absorbs stalls.
// Reset is synchronous and active low: it empties the queue and output register,
// clears all positions and the running sum; the decoder idles until a start item.
module run_list_to_extent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  rld_in_if.sink     in_chan,
  rld_out_if.source  out_chan
);
  import rld_pkg::*;

  logic       push_valid;
  rld_entry_t push_entry;
  logic       queue_full;
  logic       q_valid;
  rld_entry_t q_entry;
  logic       q_ready;

  rld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  rld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop_ready  (q_ready)
  );

  rld_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

endmodule

>>> hw/rtl/rld_checker.sv
module rld_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [63:0] out_first_lcn,
  input logic signed [63:0] out_extent_next_vcn,
  input logic signed [63:0] out_span_clusters,
  input logic               out_is_virtual
);
  import rld_pkg::*;

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_EXTENT || out_status == ST_END || out_status == ST_BAD))
    else $error("undefined status code");

  // End and malformed results carry no extent.
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_EXTENT |->
      out_first_lcn == 64'sd0 && out_extent_next_vcn == 64'sd0 &&
      out_span_clusters == 64'sd0 && !out_is_virtual)
    else $error("status result carries extent fields");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind run_list_to_extent_decoder rld_checker u_rld_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_status          (out_chan.status),
  .out_first_lcn       (out_chan.first_lcn),
  .out_extent_next_vcn (out_chan.extent_next_vcn),
  .out_span_clusters   (out_chan.span_clusters),
  .out_is_virtual      (out_chan.is_virtual)
);
